>>> rtl/cbc_pkg.sv
// Shared types and constants for the camera band capture block.
// Used by cbc_step.sv and camera_band_capture.sv; depends on nothing else.
package cbc_pkg;

    // Band buffer size in bytes.
    localparam int BUF_BYTES = 65536;
    localparam logic [16:0] BUF_LIMIT = 17'(BUF_BYTES);

    // Capture phases.
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_HIGH = 2'd1;
    localparam logic [1:0] PH_WAIT_LOW  = 2'd2;
    localparam logic [1:0] PH_CAPTURE   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_STORE      = 2'd0;
    localparam logic [1:0] KIND_BUFFER_FULL = 2'd1;
    localparam logic [1:0] KIND_FRAME_END  = 2'd2;

    // Register indexes (word address bits [3:2]).
    localparam logic [1:0] REG_DECIMATE  = 2'd0;
    localparam logic [1:0] REG_ROW_LEN   = 2'd1;
    localparam logic [1:0] REG_ROW_KEEP  = 2'd2;
    localparam logic [1:0] REG_PIX_KEEP  = 2'd3;

    // Register reset values.
    localparam logic [11:0] ROW_LEN_RESET  = 12'd1280;
    localparam logic [4:0]  KEEP_RESET     = 5'd4;

    typedef struct packed {
        logic        decimate_enable;
        logic [11:0] row_length_bytes;
        logic [4:0]  row_keep_every;
        logic [4:0]  pixel_keep_every;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  phase;
        logic [19:0] frame_byte_count;
        logic [19:0] band_offset;
        logic [16:0] stored_count;
        logic [11:0] byte_in_row;
        logic [3:0]  row_phase;
        logic [3:0]  pixel_phase;
        logic        half_pixel;
    } t_state;

    typedef struct packed {
        logic       mode;
        logic       vsync;
        logic       href;
        logic [7:0] bus_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] buffer_address;
        logic [7:0]  pixel_byte;
        logic [16:0] bytes_stored;
        logic [19:0] next_offset;
    } t_result;

endpackage

>>> rtl/cbc_step.sv
// Next-state and result logic for one camera bus item.
// Depends on cbc_pkg for the state, configuration, item and result types.
module cbc_step (
    input  cbc_pkg::t_cfg    i_cfg,
    input  cbc_pkg::t_state  i_state,
    input  cbc_pkg::t_item   i_item,
    output cbc_pkg::t_state  o_state,
    output logic             o_res_valid,
    output cbc_pkg::t_result o_res
);

    // Zero behaves as one; values above sixteen behave as sixteen.
    function automatic logic [4:0] keep_every(input logic [4:0] v);
        logic [4:0] r;
        begin
            if (v == 5'd0) begin
                r = 5'd1;
            end else if (v > 5'd16) begin
                r = 5'd16;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

    cbc_pkg::t_state w_adv;
    logic [4:0]      w_row_ke;
    logic [4:0]      w_pix_ke;
    logic            w_keep;

    assign w_row_ke = keep_every(i_cfg.row_keep_every);
    assign w_pix_ke = keep_every(i_cfg.pixel_keep_every);
    assign w_keep   = !i_cfg.decimate_enable
                      || ((i_state.row_phase == 4'd0) && (i_state.pixel_phase == 4'd0));

    // Position counters after one frame byte.
    always_comb begin
        w_adv = i_state;
        w_adv.frame_byte_count = i_state.frame_byte_count + 20'd1;
        if (({1'b0, i_state.byte_in_row} + 13'd1) >= {1'b0, i_cfg.row_length_bytes}) begin
            w_adv.byte_in_row = 12'd0;
            w_adv.half_pixel  = 1'b0;
            w_adv.pixel_phase = 4'd0;
            if (({1'b0, i_state.row_phase} + 5'd1) >= w_row_ke) begin
                w_adv.row_phase = 4'd0;
            end else begin
                w_adv.row_phase = i_state.row_phase + 4'd1;
            end
        end else begin
            w_adv.byte_in_row = i_state.byte_in_row + 12'd1;
            if (i_state.half_pixel) begin
                w_adv.half_pixel = 1'b0;
                if (({1'b0, i_state.pixel_phase} + 5'd1) >= w_pix_ke) begin
                    w_adv.pixel_phase = 4'd0;
                end else begin
                    w_adv.pixel_phase = i_state.pixel_phase + 4'd1;
                end
            end else begin
                w_adv.half_pixel = 1'b1;
            end
        end
    end

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        priority if (i_item.mode) begin
            o_state.phase            = cbc_pkg::PH_WAIT_HIGH;
            o_state.frame_byte_count = 20'd0;
            o_state.stored_count     = 17'd0;
            o_state.byte_in_row      = 12'd0;
            o_state.row_phase        = 4'd0;
            o_state.pixel_phase      = 4'd0;
            o_state.half_pixel       = 1'b0;
        end else if (i_state.phase == cbc_pkg::PH_WAIT_HIGH) begin
            if (i_item.vsync) begin
                o_state.phase = cbc_pkg::PH_WAIT_LOW;
            end
        end else if (i_state.phase == cbc_pkg::PH_WAIT_LOW) begin
            if (!i_item.vsync) begin
                o_state.phase = cbc_pkg::PH_CAPTURE;
            end
        end else if (i_state.phase == cbc_pkg::PH_CAPTURE) begin
            if (!i_item.href) begin
                if (i_item.vsync) begin
                    o_state.band_offset = 20'd0;
                    o_state.phase       = cbc_pkg::PH_IDLE;
                    o_res_valid         = 1'b1;
                    o_res.kind          = cbc_pkg::KIND_FRAME_END;
                    o_res.bytes_stored  = i_state.stored_count;
                    o_res.next_offset   = 20'd0;
                end
            end else if (i_state.frame_byte_count >= i_state.band_offset) begin
                if (i_state.stored_count < cbc_pkg::BUF_LIMIT) begin
                    o_state = w_adv;
                    o_state.band_offset = i_state.frame_byte_count + 20'd1;
                    if (w_keep) begin
                        o_state.stored_count = i_state.stored_count + 17'd1;
                        o_res_valid          = 1'b1;
                        o_res.kind           = cbc_pkg::KIND_STORE;
                        o_res.buffer_address = i_state.stored_count[15:0];
                        o_res.pixel_byte     = i_item.bus_byte;
                        o_res.bytes_stored   = i_state.stored_count + 17'd1;
                    end
                    o_res.next_offset = i_state.frame_byte_count + 20'd1;
                end else begin
                    o_state.phase      = cbc_pkg::PH_IDLE;
                    o_res_valid        = 1'b1;
                    o_res.kind         = cbc_pkg::KIND_BUFFER_FULL;
                    o_res.bytes_stored = i_state.stored_count;
                    o_res.next_offset  = i_state.band_offset;
                end
            end else begin
                o_state = w_adv;
            end
        end else begin
            o_state = i_state;
        end
    end

endmodule

>>> rtl/camera_band_capture.sv
// Top level of the camera band capture block: stream ports, register port and pipeline.
// Depends on cbc_pkg and cbc_step.
//
// This block turns samples of a camera parallel port into buffer write
// transactions. Each input transaction is one pixel-clock edge (vsync, href
// and the data byte) or, with tuser high, an arm command that clears the band
// buffer and waits for vsync to go high and then low. While href is high every
// edge is one frame byte; bytes at or past the band offset are written to the
// buffer in order, optionally thinned to selected rows and pixels. When the
// buffer is full the next such byte ends the band and the offset is kept, so
// that re-arming captures the following band; vsync while href is low ends the
// frame and sets the offset back to zero. The block takes one transaction in every
// clock cycle unless the output stalls; a result passes the input register, the
// single state-update stage and the result register. A stalled output holds the
// pipeline, and input tready then falls. The user must write registers through
// the APB port only while no transactions are in flight; the block does not enforce it.
module camera_band_capture (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: tdata = vsync [0], href [1], bus_byte [9:2], zero fill [15:10].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // tuser = mode (0 pixel edge, 1 arm).
    input  logic        s_axis_tuser,
    // Master stream: tdata = buffer_address [15:0], pixel_byte [23:16],
    // bytes_stored [40:24], next_offset [60:41], zero fill [63:61].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    // tuser = kind (0 byte stored, 1 buffer full, 2 frame ended).
    output logic [1:0]  m_axis_tuser,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cbc_pkg::t_cfg    r_cfg;
    cbc_pkg::t_state  r_state;
    cbc_pkg::t_state  n_state;
    cbc_pkg::t_item   r_item;
    logic             r_in_valid;
    cbc_pkg::t_result r_res;
    logic             r_out_valid;
    cbc_pkg::t_result w_res;
    logic             w_res_valid;
    logic             w_step;
    logic             w_cfg_wr;

    // ------------------------------------------------------------------
    // Register port. pready is tied high, so every access completes in the
    // access cycle. Word address bits [3:2] select the register.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decimate_enable  <= 1'b0;
            r_cfg.row_length_bytes <= cbc_pkg::ROW_LEN_RESET;
            r_cfg.row_keep_every   <= cbc_pkg::KEEP_RESET;
            r_cfg.pixel_keep_every <= cbc_pkg::KEEP_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                cbc_pkg::REG_DECIMATE: r_cfg.decimate_enable  <= pwdata[0];
                cbc_pkg::REG_ROW_LEN:  r_cfg.row_length_bytes <= pwdata[11:0];
                cbc_pkg::REG_ROW_KEEP: r_cfg.row_keep_every   <= pwdata[4:0];
                cbc_pkg::REG_PIX_KEEP: r_cfg.pixel_keep_every <= pwdata[4:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            cbc_pkg::REG_DECIMATE: prdata = {31'd0, r_cfg.decimate_enable};
            cbc_pkg::REG_ROW_LEN:  prdata = {20'd0, r_cfg.row_length_bytes};
            cbc_pkg::REG_ROW_KEEP: prdata = {27'd0, r_cfg.row_keep_every};
            cbc_pkg::REG_PIX_KEEP: prdata = {27'd0, r_cfg.pixel_keep_every};
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline. The registered item is processed, and the capture state
    // updated, in the cycle that the result register can take its result.
    // An item that causes no result simply leaves the input register.
    // ------------------------------------------------------------------
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.mode     <= s_axis_tuser;
            r_item.vsync    <= s_axis_tdata[0];
            r_item.href     <= s_axis_tdata[1];
            r_item.bus_byte <= s_axis_tdata[9:2];
        end
    end

    cbc_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_item      (r_item),
        .o_state     (n_state),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_step) begin
            r_state <= n_state;
        end
    end

    // Result register: refilled when a step yields a result, emptied when
    // the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tdata  = {3'd0, r_res.next_offset, r_res.bytes_stored,
                            r_res.pixel_byte, r_res.buffer_address};

`ifndef SYNTHESIS
    // A stored byte always leaves the buffer holding one byte past its address.
    a_store_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == cbc_pkg::KIND_STORE))
        |-> (r_res.bytes_stored == ({1'b0, r_res.buffer_address} + 17'd1)))
        else $error("stored byte count does not follow its address");

    // The fill count never passes the buffer size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stored_count <= cbc_pkg::BUF_LIMIT)
        else $error("stored count exceeds buffer size");

    // A band or frame end always leaves the capture idle.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res_valid && (w_res.kind != cbc_pkg::KIND_STORE))
        |=> (r_state.phase == cbc_pkg::PH_IDLE))
        else $error("capture not idle after band or frame end");

    // A frame end reports, and leaves, a zero band offset.
    a_frame_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res_valid && (w_res.kind == cbc_pkg::KIND_FRAME_END))
        |=> ((r_state.band_offset == 20'd0) && (r_res.next_offset == 20'd0)))
        else $error("band offset not cleared at frame end");
`endif

endmodule
